### sv/alm_pkg.sv
// Shared types and constants for the audio level meter.
// Depends on nothing; alm_dp, alm_ctrl and the top level import it.
package alm_pkg;

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int RMS_WINDOW_DEF   = 8;
    localparam int MAX_BLOCK_DEF    = 4096;

    localparam int CH_W       = 3;
    localparam int SMP_W      = 24;
    localparam int MAG_W      = 23;
    localparam int PK_W       = 39;
    localparam int MS_W       = 45;
    localparam int SQ_IN_W    = 46;
    localparam int ROOT_W     = 23;
    localparam int ACT_W      = 4;
    localparam int DEC_W      = 24;
    localparam int COEF_W     = 25;
    localparam int PROD_W     = 48;
    localparam int SPLIT      = 20;
    localparam int FRAC_W     = 24;
    localparam int LVL_SHIFT  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    localparam logic [SMP_W-1:0]  LIMIT_Q19 = 24'd5242880;
    localparam logic [MAG_W-1:0]  UNIT_Q19  = 23'd524288;
    localparam logic [COEF_W-1:0] VU_ONE    = 25'd16777216;
    localparam logic [DEC_W-1:0]  DECAY_RST = 24'd16776340;
    localparam logic [COEF_W-1:0] VU_RST    = 25'd5839;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VU     = 2'd2;

    localparam logic [2:0] MUL_NONE = 3'd0;
    localparam logic [2:0] MUL_SQ   = 3'd1;
    localparam logic [2:0] MUL_PL   = 3'd2;
    localparam logic [2:0] MUL_PH   = 3'd3;
    localparam logic [2:0] MUL_VL   = 3'd4;
    localparam logic [2:0] MUL_VH   = 3'd5;

    typedef struct packed {
        logic       capture;
        logic       load_rec;
        logic [2:0] mul_op;
        logic       update;
        logic       wr_rec;
        logic       div_mean;
        logic       div_rms;
        logic       ring_upd;
        logic       sqrt_start;
        logic       out_load;
    } alm_cmd_t;

    typedef struct packed {
        logic ch_active;
        logic blk_end;
        logic div_done;
        logic sqrt_done;
    } alm_stat_t;

endpackage

### sv/alm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the channel records and the mean-square ring.
module alm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/alm_div.sv
// Restoring divider, one quotient bit per cycle.
// Stand-alone iterative unit shared by the mean and the window average.
module alm_div #(
    parameter int NUM_W = 58,
    parameter int DEN_W = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output logic             done
);
    localparam int CW = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg;
    logic [DEN_W:0]   rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   rem_sh;
    logic             fits;

    assign rem_sh = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg && cnt_reg == CW'(1))
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            cnt_reg <= CW'(NUM_W);
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;
endmodule

### sv/alm_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle, truncating.
// Stand-alone iterative unit for the RMS value.
module alm_sqrt #(
    parameter int ROOT_W = 23
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2*ROOT_W-1:0] radicand,
    output logic [ROOT_W-1:0]   root,
    output logic                done
);
    localparam int CW = $clog2(ROOT_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CW-1:0]       cnt_reg;
    logic [ROOT_W:0]     rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [2*ROOT_W-1:0] val_reg;
    logic [ROOT_W+2:0]   rem_sh;
    logic [ROOT_W+2:0]   trial;
    logic                fits;

    assign rem_sh = {rem_reg, val_reg[2*ROOT_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg && cnt_reg == CW'(1))
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= CW'(ROOT_W);
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? (ROOT_W + 1)'(rem_sh - trial) : (ROOT_W + 1)'(rem_sh);
            root_reg <= {root_reg[ROOT_W-2:0], fits};
            val_reg  <= {val_reg[2*ROOT_W-3:0], 2'b00};
            cnt_reg  <= cnt_reg - 1'b1;
        end
    end

    assign root = root_reg;
    assign done = done_reg;
endmodule

### sv/alm_dp.sv
// Datapath of the level meter: configuration, channel records, multiplier, ring.
// Depends on alm_pkg, alm_ram, alm_div and alm_sqrt.
module alm_dp #(
    parameter int MAX_CHANNELS = alm_pkg::MAX_CHANNELS_DEF,
    parameter int RMS_WINDOW   = alm_pkg::RMS_WINDOW_DEF,
    parameter int MAX_BLOCK    = alm_pkg::MAX_BLOCK_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [alm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [alm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [alm_pkg::CH_W-1:0]           channel_index,
    input  logic signed [alm_pkg::SMP_W-1:0]   sample_value,
    input  logic                               last_of_block,
    input  logic                               clear_clip,
    input  alm_pkg::alm_cmd_t                  cmd,
    output alm_pkg::alm_stat_t                 stat,
    output logic [alm_pkg::CH_W-1:0]           report_channel,
    output logic [alm_pkg::MAG_W-1:0]          peak_level,
    output logic [alm_pkg::MAG_W-1:0]          vu_level,
    output logic [alm_pkg::MAG_W-1:0]          rms_level,
    output logic                               clip_seen
);
    import alm_pkg::*;

    localparam int CH_AW   = MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1;
    localparam int SL_W    = RMS_WINDOW > 1 ? $clog2(RMS_WINDOW) : 1;
    localparam int SE_W    = $clog2(RMS_WINDOW + 1);
    localparam int CNT_W   = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W   = MS_W + CNT_W;
    localparam int TOT_W   = MS_W + SE_W;
    localparam int NUM_W   = SUM_W > TOT_W ? SUM_W : TOT_W;
    localparam int DEN_W   = CNT_W > SE_W ? CNT_W : SE_W;
    localparam int RING_AW = CH_AW + SL_W;
    localparam int WIDE_W  = PROD_W + SPLIT;

    typedef struct packed {
        logic [PK_W-1:0]  peak;
        logic [PK_W-1:0]  vu;
        logic             clip;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
        logic [TOT_W-1:0] total;
        logic [SL_W-1:0]  slot;
        logic [SE_W-1:0]  seen;
    } rec_t;

    logic [ACT_W-1:0]        active_reg;
    logic [DEC_W-1:0]        decay_reg;
    logic [COEF_W-1:0]       coeff_reg;
    logic [MAX_CHANNELS-1:0] chan_valid_reg;

    logic [CH_W-1:0]   ch_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic              last_reg;
    logic              clr_reg;
    logic              blk_end_reg;
    logic [PK_W-1:0]   peak_reg;
    logic [PK_W-1:0]   vu_reg;
    logic              clip_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [TOT_W-1:0]  total_reg;
    logic [SL_W-1:0]   slot_reg;
    logic [SE_W-1:0]   seen_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] acc_reg;

    logic [CH_AW-1:0]   ch_addr;
    logic [SMP_W-1:0]   abs_smp;
    logic [MAG_W-1:0]   mag_c;
    logic [COEF_W-1:0]  coeff_use;
    logic [PK_W-1:0]    big;
    logic               vu_ge;
    logic [PK_W-1:0]    diff;
    logic [MAG_W-1:0]   opa;
    logic [COEF_W-1:0]  opb;
    logic [WIDE_W-1:0]  wide;
    logic [PK_W-1:0]    wide_q;
    logic [CNT_W-1:0]   cnt_inc;
    rec_t               rec_rd;
    rec_t               rec_wr;
    logic [MS_W-1:0]    ring_rd;
    logic [MS_W-1:0]    ring_old;
    logic [MS_W-1:0]    mean;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic [NUM_W-1:0]   div_quo;
    logic               div_done;
    logic [ROOT_W-1:0]  root;
    logic               sqrt_done;
    logic [RING_AW-1:0] ring_addr;

    // Configuration registers and per-channel valid bits. A channel that is not
    // valid reads as all zero, which is its cleared state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            decay_reg      <= DECAY_RST;
            coeff_reg      <= VU_RST;
            chan_valid_reg <= '0;
        end
        else
        begin
            if (cmd.wr_rec)
            begin
                chan_valid_reg[ch_addr] <= 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ACTIVE:
                    begin
                        active_reg <= cfg_data[ACT_W-1:0];
                        for (int c = 0; c < MAX_CHANNELS; c++)
                        begin
                            if (c >= int'(cfg_data[ACT_W-1:0]))
                            begin
                                chan_valid_reg[c] <= 1'b0;
                            end
                        end
                    end
                    CFG_DECAY: decay_reg <= cfg_data[DEC_W-1:0];
                    CFG_VU:    coeff_reg <= cfg_data[COEF_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    assign ch_addr = CH_AW'(ch_reg);
    assign abs_smp = sample_value[SMP_W-1] ? (~sample_value + 1'b1) : sample_value;
    assign mag_c   = (abs_smp > LIMIT_Q19) ? '0 : abs_smp[MAG_W-1:0];

    assign coeff_use = (coeff_reg > VU_ONE) ? VU_ONE : coeff_reg;
    assign big       = {mag_reg, {LVL_SHIFT{1'b0}}};
    assign vu_ge     = big >= vu_reg;
    assign diff      = vu_ge ? (big - vu_reg) : (vu_reg - big);
    assign cnt_inc   = cnt_reg + 1'b1;

    always_comb
    begin
        opa = '0;
        opb = '0;
        unique case (cmd.mul_op)
            MUL_SQ:
            begin
                opa = mag_reg;
                opb = COEF_W'(mag_reg);
            end
            MUL_PL:
            begin
                opa = MAG_W'(peak_reg[SPLIT-1:0]);
                opb = COEF_W'(decay_reg);
            end
            MUL_PH:
            begin
                opa = MAG_W'(peak_reg[PK_W-1:SPLIT]);
                opb = COEF_W'(decay_reg);
            end
            MUL_VL:
            begin
                opa = MAG_W'(diff[SPLIT-1:0]);
                opb = coeff_use;
            end
            MUL_VH:
            begin
                opa = MAG_W'(diff[PK_W-1:SPLIT]);
                opb = coeff_use;
            end
            default: ;
        endcase
    end

    // Low partial product sits in acc_reg, high partial in prod_reg.
    assign wide   = WIDE_W'(acc_reg) + {prod_reg, {SPLIT{1'b0}}};
    assign wide_q = wide[FRAC_W+PK_W-1:FRAC_W];

    // An unfilled window position was never written since the channel was cleared.
    assign ring_old = (seen_reg == SE_W'(RMS_WINDOW)) ? ring_rd : '0;
    assign mean     = div_quo[MS_W-1:0];

    assign rec_wr.peak  = peak_reg;
    assign rec_wr.vu    = vu_reg;
    assign rec_wr.clip  = clip_reg & ~(clr_reg & blk_end_reg);
    assign rec_wr.sum   = sum_reg;
    assign rec_wr.cnt   = cnt_reg;
    assign rec_wr.total = total_reg;
    assign rec_wr.slot  = slot_reg;
    assign rec_wr.seen  = seen_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg   <= channel_index;
            mag_reg  <= mag_c;
            last_reg <= last_of_block;
            clr_reg  <= clear_clip;
        end
        if (cmd.load_rec)
        begin
            if (chan_valid_reg[ch_addr])
            begin
                peak_reg  <= rec_rd.peak;
                vu_reg    <= rec_rd.vu;
                clip_reg  <= rec_rd.clip;
                sum_reg   <= rec_rd.sum;
                cnt_reg   <= rec_rd.cnt;
                total_reg <= rec_rd.total;
                slot_reg  <= rec_rd.slot;
                seen_reg  <= rec_rd.seen;
            end
            else
            begin
                peak_reg  <= '0;
                vu_reg    <= '0;
                clip_reg  <= 1'b0;
                sum_reg   <= '0;
                cnt_reg   <= '0;
                total_reg <= '0;
                slot_reg  <= '0;
                seen_reg  <= '0;
            end
        end
        if (cmd.mul_op != MUL_NONE)
        begin
            prod_reg <= PROD_W'(opa) * PROD_W'(opb);
        end
        unique case (cmd.mul_op)
            MUL_PL: sum_reg <= sum_reg + SUM_W'(prod_reg);
            MUL_PH: acc_reg <= prod_reg;
            MUL_VL: peak_reg <= (big > peak_reg) ? big : wide_q;
            MUL_VH: acc_reg <= prod_reg;
            default: ;
        endcase
        if (cmd.update)
        begin
            vu_reg      <= vu_ge ? (vu_reg + wide_q) : (vu_reg - wide_q);
            clip_reg    <= clip_reg | (mag_reg > UNIT_Q19);
            cnt_reg     <= cnt_inc;
            blk_end_reg <= last_reg || (cnt_inc == CNT_W'(MAX_BLOCK));
        end
        if (cmd.ring_upd)
        begin
            total_reg <= total_reg - TOT_W'(ring_old) + TOT_W'(mean);
            slot_reg  <= (slot_reg == SL_W'(RMS_WINDOW - 1)) ? '0 : slot_reg + 1'b1;
            if (seen_reg != SE_W'(RMS_WINDOW))
            begin
                seen_reg <= seen_reg + 1'b1;
            end
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.out_load)
        begin
            report_channel <= ch_reg;
            peak_level     <= peak_reg[PK_W-1:LVL_SHIFT];
            vu_level       <= vu_reg[PK_W-1:LVL_SHIFT];
            rms_level      <= root;
            clip_seen      <= clip_reg;
        end
    end

    alm_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (2 ** CH_AW)
    ) u_chan_ram (
        .clk   (clk),
        .we    (cmd.wr_rec),
        .waddr (ch_addr),
        .wdata (rec_wr),
        .raddr (CH_AW'(channel_index)),
        .rdata (rec_rd)
    );

    assign ring_addr = {ch_addr, slot_reg};

    alm_ram #(
        .WIDTH (MS_W),
        .DEPTH (2 ** RING_AW)
    ) u_ring_ram (
        .clk   (clk),
        .we    (cmd.ring_upd),
        .waddr (ring_addr),
        .wdata (mean),
        .raddr (ring_addr),
        .rdata (ring_rd)
    );

    assign div_num = cmd.div_mean ? NUM_W'(sum_reg) : NUM_W'(total_reg);
    assign div_den = cmd.div_mean ? DEN_W'(cnt_reg) : DEN_W'(seen_reg);

    alm_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_mean | cmd.div_rms),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    alm_sqrt #(
        .ROOT_W (ROOT_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (SQ_IN_W'(div_quo)),
        .root     (root),
        .done     (sqrt_done)
    );

    assign stat.ch_active = (int'(channel_index) < int'(active_reg))
                            && (int'(channel_index) < MAX_CHANNELS);
    assign stat.blk_end   = blk_end_reg;
    assign stat.div_done  = div_done;
    assign stat.sqrt_done = sqrt_done;
endmodule

### sv/alm_ctrl.sv
// Controller state machine of the level meter: sequences the datapath.
// Depends on alm_pkg.
module alm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  alm_pkg::alm_stat_t stat,
    output alm_pkg::alm_cmd_t  cmd
);
    import alm_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_MSQ   = 4'd2;
    localparam logic [3:0] S_MPL   = 4'd3;
    localparam logic [3:0] S_MPH   = 4'd4;
    localparam logic [3:0] S_MVL   = 4'd5;
    localparam logic [3:0] S_MVH   = 4'd6;
    localparam logic [3:0] S_UPD   = 4'd7;
    localparam logic [3:0] S_DEC   = 4'd8;
    localparam logic [3:0] S_MDIV  = 4'd9;
    localparam logic [3:0] S_RING  = 4'd10;
    localparam logic [3:0] S_RSTRT = 4'd11;
    localparam logic [3:0] S_RDIV  = 4'd12;
    localparam logic [3:0] S_SQRT  = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && stat.ch_active)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_rec = 1'b1;
                state_next   = S_MSQ;
            end
            S_MSQ:
            begin
                cmd.mul_op = MUL_SQ;
                state_next = S_MPL;
            end
            S_MPL:
            begin
                cmd.mul_op = MUL_PL;
                state_next = S_MPH;
            end
            S_MPH:
            begin
                cmd.mul_op = MUL_PH;
                state_next = S_MVL;
            end
            S_MVL:
            begin
                cmd.mul_op = MUL_VL;
                state_next = S_MVH;
            end
            S_MVH:
            begin
                cmd.mul_op = MUL_VH;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (stat.blk_end)
                begin
                    cmd.div_mean = 1'b1;
                    state_next   = S_MDIV;
                end
                else
                begin
                    cmd.wr_rec = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MDIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_RING;
                end
            end
            S_RING:
            begin
                cmd.ring_upd = 1'b1;
                state_next   = S_RSTRT;
            end
            S_RSTRT:
            begin
                cmd.div_rms = 1'b1;
                state_next  = S_RDIV;
            end
            S_RDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (stat.sqrt_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.wr_rec   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

    // A sample of an inactive channel is dropped without leaving idle.
    a_drop_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid && !stat.ch_active) |=> state_reg == S_IDLE)
        else $error("inactive channel sample started work");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

    a_result_taken: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(!out_stall))
        else $error("result dropped while stalled");

    a_mean_to_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MDIV && stat.div_done) |=> cmd.ring_upd)
        else $error("ring update skipped after mean");
endmodule

### sv/audio_level_meter.sv
// Top level of the multichannel peak / VU / RMS audio level meter.
// Depends on alm_pkg, alm_ctrl and alm_dp.
//
//   channel   handshake            payload
//   config    cfg_we               cfg_index, cfg_data
//   sample    in_valid / in_stall  channel_index, sample_value, last_of_block, clear_clip
//   report    out_valid / out_stall report_channel, peak_level, vu_level, rms_level, clip_seen
//
// A sample that does not end a block is loaded, passes the five steps of the one
// shared 23x25 multiplier and is updated before the next acceptance.
// A block-ending sample adds the bit-serial divider, run twice, and the
// bit-serial root, plus any time that the report waits for a stalled output
// register.
// Reset clears all channels at once through per-channel valid bits; no clearing pass.
// One transaction is in work at a time; a finished report waits in the output
// register under out_stall while the next sample is taken.
module audio_level_meter #(
    parameter int MAX_CHANNELS = alm_pkg::MAX_CHANNELS_DEF,
    parameter int RMS_WINDOW   = alm_pkg::RMS_WINDOW_DEF,
    parameter int MAX_BLOCK    = alm_pkg::MAX_BLOCK_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [alm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [alm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [alm_pkg::CH_W-1:0]           channel_index,
    input  logic signed [alm_pkg::SMP_W-1:0]   sample_value,
    input  logic                               last_of_block,
    input  logic                               clear_clip,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [alm_pkg::CH_W-1:0]           report_channel,
    output logic [alm_pkg::MAG_W-1:0]          peak_level,
    output logic [alm_pkg::MAG_W-1:0]          vu_level,
    output logic [alm_pkg::MAG_W-1:0]          rms_level,
    output logic                               clip_seen
);
    import alm_pkg::*;

    alm_cmd_t  cmd;
    alm_stat_t stat;

    alm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    alm_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .RMS_WINDOW   (RMS_WINDOW),
        .MAX_BLOCK    (MAX_BLOCK)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .channel_index  (channel_index),
        .sample_value   (sample_value),
        .last_of_block  (last_of_block),
        .clear_clip     (clear_clip),
        .cmd            (cmd),
        .stat           (stat),
        .report_channel (report_channel),
        .peak_level     (peak_level),
        .vu_level       (vu_level),
        .rms_level      (rms_level),
        .clip_seen      (clip_seen)
    );
endmodule
